// File: design/gpioprb_pkg.sv
// Package for the GPIO port register block: item kinds, register offsets,
// configuration indexes and stream layout constants. No dependencies.

package gpioprb_pkg;

    localparam int PIN_COUNT_DEFAULT = 16;

    typedef enum logic [1:0] {
        KIND_READ       = 2'd0,
        KIND_WRITE      = 2'd1,
        KIND_SET_PIN    = 2'd2,
        KIND_SOFT_RESET = 2'd3
    } item_kind_t;

    localparam logic [1:0] CFG_MODE_RESET  = 2'd0;
    localparam logic [1:0] CFG_SPEED_RESET = 2'd1;
    localparam logic [1:0] CFG_PULL_RESET  = 2'd2;
    localparam logic [1:0] CFG_NOTIFY_EN   = 2'd3;

    localparam logic [9:0] OFS_MODE     = 10'h000;
    localparam logic [9:0] OFS_TYPE     = 10'h004;
    localparam logic [9:0] OFS_SPEED    = 10'h008;
    localparam logic [9:0] OFS_PULL     = 10'h00C;
    localparam logic [9:0] OFS_IDR      = 10'h010;
    localparam logic [9:0] OFS_ODR      = 10'h014;
    localparam logic [9:0] OFS_BSRR     = 10'h018;
    localparam logic [9:0] OFS_LOCK     = 10'h01C;
    localparam logic [9:0] OFS_AF_LOW   = 10'h020;
    localparam logic [9:0] OFS_AF_HIGH  = 10'h024;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 56;

endpackage

// File: design/gpio_port_register_block_unit.sv
// GPIO port register block, top level: input beat register, register file,
// set/reset logic and a result stage that drains pin-change events.
// Depends on gpioprb_pkg.
//
// An accepted beat passes the input beat register, then the result stage.
// Throughput: one item per cycle while the result stage is free; a write that
// changes k output pins with notify enabled gives k results, one per ready cycle.
// Reset (rst_n low, async): config cleared, registers at reset values,
// input data all ones within the pin mask, both stages empty.

module gpio_port_register_block_unit
    import gpioprb_pkg::*;
#(
    parameter int PIN_COUNT = PIN_COUNT_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [31:0]           cfg_wdata,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // offset[9:0], write_data[41:10], pin_index[45:42], pin_level[46], zero[47]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // mode[1:0]
    input  logic [1:0]            s_axis_tuser,

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // read_data[31:0], output_pins[47:32], event_pin[51:48], event_level[52],
    // zero[55:53]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // has_event[0]
    output logic                  m_axis_tuser,
    output logic                  m_axis_tlast
);

    localparam logic [15:0] PinMask = 16'((32'd1 << PIN_COUNT) - 32'd1);

    // configuration
    logic [31:0] mode_reset_value_reg;
    logic [31:0] speed_reset_value_reg;
    logic [31:0] pull_reset_value_reg;
    logic        notify_enable_reg;

    // port registers
    logic [31:0] pin_mode_reg,      pin_mode_next;
    logic [31:0] output_type_reg,   output_type_next;
    logic [31:0] output_speed_reg,  output_speed_next;
    logic [31:0] pull_reg,          pull_next;
    logic [15:0] input_data_reg,    input_data_next;
    logic [15:0] output_data_reg,   output_data_next;
    logic [31:0] lock_reg,          lock_next;
    logic [31:0] alt_func_low_reg,  alt_func_low_next;
    logic [31:0] alt_func_high_reg, alt_func_high_next;

    // input stage
    logic        in_valid_reg;
    item_kind_t  in_kind_reg;
    logic [9:0]  in_offset_reg;
    logic [31:0] in_wdata_reg;
    logic [3:0]  in_pin_reg;
    logic        in_level_reg;

    // result stage
    logic                 out_valid_reg;
    logic                 out_event_reg;
    logic [PIN_COUNT-1:0] out_pend_reg;
    logic [31:0]          out_rdata_reg;
    logic [15:0]          out_pins_reg;

    logic                 out_free;
    logic                 out_load;
    logic                 out_last;
    logic                 out_take;
    logic [PIN_COUNT-1:0] pend_low;
    logic [3:0]           ev_pin;
    logic                 ev_level;

    logic [31:0]          rdata_calc;
    logic [PIN_COUNT-1:0] changed;
    logic                 is_event;
    logic [15:0]          bsrr_set;
    logic [15:0]          bsrr_clr;

    assign out_take      = out_valid_reg && m_axis_tready;
    assign out_free      = !out_valid_reg || (out_take && out_last);
    assign out_load      = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reset_value_reg  <= '0;
            speed_reset_value_reg <= '0;
            pull_reset_value_reg  <= '0;
            notify_enable_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MODE_RESET:  mode_reset_value_reg  <= cfg_wdata;
                CFG_SPEED_RESET: speed_reset_value_reg <= cfg_wdata;
                CFG_PULL_RESET:  pull_reset_value_reg  <= cfg_wdata;
                CFG_NOTIFY_EN:   notify_enable_reg     <= cfg_wdata[0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_kind_reg   <= item_kind_t'(s_axis_tuser);
            in_offset_reg <= s_axis_tdata[9:0];
            in_wdata_reg  <= s_axis_tdata[41:10];
            in_pin_reg    <= s_axis_tdata[45:42];
            in_level_reg  <= s_axis_tdata[46];
        end
    end

    always_comb
    begin
        case (in_offset_reg)
            OFS_MODE:    rdata_calc = pin_mode_reg;
            OFS_TYPE:    rdata_calc = output_type_reg;
            OFS_SPEED:   rdata_calc = output_speed_reg;
            OFS_PULL:    rdata_calc = pull_reg;
            OFS_IDR:     rdata_calc = {16'h0000, input_data_reg};
            OFS_ODR:     rdata_calc = {16'h0000, output_data_reg};
            OFS_LOCK:    rdata_calc = lock_reg;
            OFS_AF_LOW:  rdata_calc = alt_func_low_reg;
            OFS_AF_HIGH: rdata_calc = alt_func_high_reg;
            default:     rdata_calc = '0;
        endcase
    end

    assign bsrr_set = in_wdata_reg[15:0];
    assign bsrr_clr = in_wdata_reg[31:16];

    always_comb
    begin
        pin_mode_next      = pin_mode_reg;
        output_type_next   = output_type_reg;
        output_speed_next  = output_speed_reg;
        pull_next          = pull_reg;
        input_data_next    = input_data_reg;
        output_data_next   = output_data_reg;
        lock_next          = lock_reg;
        alt_func_low_next  = alt_func_low_reg;
        alt_func_high_next = alt_func_high_reg;
        unique case (in_kind_reg)
            KIND_READ:
            begin
            end
            KIND_WRITE:
            begin
                case (in_offset_reg)
                    OFS_MODE:    pin_mode_next      = in_wdata_reg;
                    OFS_TYPE:    output_type_next   = in_wdata_reg;
                    OFS_SPEED:   output_speed_next  = in_wdata_reg;
                    OFS_PULL:    pull_next          = in_wdata_reg;
                    OFS_ODR:     output_data_next   = in_wdata_reg[15:0] & PinMask;
                    OFS_BSRR:    output_data_next   =
                                     ((output_data_reg | bsrr_set) & ~bsrr_clr) & PinMask;
                    OFS_LOCK:    lock_next          = in_wdata_reg;
                    OFS_AF_LOW:  alt_func_low_next  = in_wdata_reg;
                    OFS_AF_HIGH: alt_func_high_next = in_wdata_reg;
                    default:
                    begin
                    end
                endcase
            end
            KIND_SET_PIN:
            begin
                if ({1'b0, in_pin_reg} < 5'(PIN_COUNT))
                begin
                    input_data_next[in_pin_reg] = in_level_reg;
                end
            end
            KIND_SOFT_RESET:
            begin
                pin_mode_next      = mode_reset_value_reg;
                output_type_next   = '0;
                output_speed_next  = speed_reset_value_reg;
                pull_next          = pull_reset_value_reg;
                input_data_next    = PinMask;
                output_data_next   = '0;
                lock_next          = '0;
                alt_func_low_next  = '0;
                alt_func_high_next = '0;
            end
        endcase
    end

    assign changed  = PIN_COUNT'((output_data_reg ^ output_data_next) & PinMask);
    assign is_event = (in_kind_reg == KIND_WRITE) && notify_enable_reg && (changed != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pin_mode_reg      <= '0;
            output_type_reg   <= '0;
            output_speed_reg  <= '0;
            pull_reg          <= '0;
            input_data_reg    <= PinMask;
            output_data_reg   <= '0;
            lock_reg          <= '0;
            alt_func_low_reg  <= '0;
            alt_func_high_reg <= '0;
        end
        else if (out_load)
        begin
            pin_mode_reg      <= pin_mode_next;
            output_type_reg   <= output_type_next;
            output_speed_reg  <= output_speed_next;
            pull_reg          <= pull_next;
            input_data_reg    <= input_data_next;
            output_data_reg   <= output_data_next;
            lock_reg          <= lock_next;
            alt_func_low_reg  <= alt_func_low_next;
            alt_func_high_reg <= alt_func_high_next;
        end
    end

    // lowest pending pin goes out first
    assign pend_low = out_pend_reg & (~out_pend_reg + 1'b1);

    always_comb
    begin
        ev_pin = '0;
        for (int i = 0; i < PIN_COUNT; i++)
        begin
            if (pend_low[i])
            begin
                ev_pin = ev_pin | 4'(i);
            end
        end
    end

    assign ev_level = out_pins_reg[ev_pin];
    assign out_last = !out_event_reg || ((out_pend_reg & ~pend_low) == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_event_reg <= 1'b0;
            out_pend_reg  <= '0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
            out_event_reg <= is_event;
            out_pend_reg  <= is_event ? changed : '0;
        end
        else if (out_take)
        begin
            if (out_last)
            begin
                out_valid_reg <= 1'b0;
            end
            out_pend_reg <= out_pend_reg & ~pend_low;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_rdata_reg <= (in_kind_reg == KIND_READ) ? rdata_calc : '0;
            out_pins_reg  <= output_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_event_reg;
    assign m_axis_tlast  = out_last;
    assign m_axis_tdata  = {3'b000,
                            ev_level & out_event_reg,
                            out_event_reg ? ev_pin : 4'h0,
                            out_pins_reg,
                            out_rdata_reg};

endmodule

// File: design/gpioprb_checker.sv
// Port-level checker for the GPIO port register block, with its bind.
// Depends on gpioprb_pkg for the stream widths.

module gpioprb_checker
    import gpioprb_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic                  m_axis_tuser,
    input logic                  m_axis_tlast
);

    // a plain result is always the only one of its item
    a_plain_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
        else $error("plain result without last");

    a_event_no_rdata: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[31:0] == 32'h0)
        else $error("event beat carries read data");

    // events of one item follow in ascending pin order with a fixed pin image
    a_event_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tuser && !m_axis_tlast |=>
        m_axis_tvalid && m_axis_tuser
        && (m_axis_tdata[51:48] > $past(m_axis_tdata[51:48]))
        && (m_axis_tdata[47:32] == $past(m_axis_tdata[47:32])))
        else $error("event beats out of order");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
        && $stable(m_axis_tuser))
        else $error("stalled output beat changed");

endmodule

bind gpio_port_register_block_unit gpioprb_checker u_gpioprb_checker (.*);

// File: tb/gpio_port_register_block_unit_tb.sv
// Testbench for gpio_port_register_block_unit: a shadow of the port registers
// predicts every result beat, and plain tasks drive the stream and config ports.
// Depends on gpioprb_pkg and the gpio_port_register_block_unit RTL.

module gpio_port_register_block_unit_tb;
    import gpioprb_pkg::*;

    typedef struct packed {
        logic [31:0] read_data;
        logic [15:0] output_pins;
        logic        has_event;
        logic [3:0]  event_pin;
        logic        event_level;
        logic        last;
    } gpio_result_t;

    class gpio_port_shadow;
        logic [31:0]  mode_rst;
        logic [31:0]  speed_rst;
        logic [31:0]  pull_rst;
        logic         notify;
        logic [31:0]  mode_r;
        logic [31:0]  type_r;
        logic [31:0]  speed_r;
        logic [31:0]  pull_r;
        logic [31:0]  lock_r;
        logic [31:0]  af_lo;
        logic [31:0]  af_hi;
        logic [15:0]  idr;
        logic [15:0]  odr;
        gpio_result_t pending_results[$];
        int           mismatches;

        function void soft_reset();
            mode_r  = mode_rst;
            speed_r = speed_rst;
            pull_r  = pull_rst;
            type_r  = '0;
            lock_r  = '0;
            af_lo   = '0;
            af_hi   = '0;
            odr     = '0;
            idr     = 16'hFFFF;
        endfunction

        function void hard_reset();
            mode_rst   = '0;
            speed_rst  = '0;
            pull_rst   = '0;
            notify     = 1'b0;
            mismatches = 0;
            pending_results.delete();
            soft_reset();
        endfunction

        function void set_config(logic [1:0] idx, logic [31:0] v);
            case (idx)
                CFG_MODE_RESET:  mode_rst  = v;
                CFG_SPEED_RESET: speed_rst = v;
                CFG_PULL_RESET:  pull_rst  = v;
                CFG_NOTIFY_EN:   notify    = v[0];
                default: ;
            endcase
        endfunction

        function void note_item(item_kind_t kind, logic [9:0] off, logic [31:0] data,
                                logic [3:0] pin, logic lvl);
            gpio_result_t r;
            logic [15:0]  prev;
            logic [15:0]  changed;
            int           total;
            int           n;
            r = '0;
            r.last = 1'b1;
            case (kind)
                KIND_READ:
                begin
                    case (off)
                        OFS_MODE:    r.read_data = mode_r;
                        OFS_TYPE:    r.read_data = type_r;
                        OFS_SPEED:   r.read_data = speed_r;
                        OFS_PULL:    r.read_data = pull_r;
                        OFS_IDR:     r.read_data = {16'h0, idr};
                        OFS_ODR:     r.read_data = {16'h0, odr};
                        OFS_LOCK:    r.read_data = lock_r;
                        OFS_AF_LOW:  r.read_data = af_lo;
                        OFS_AF_HIGH: r.read_data = af_hi;
                        default:     r.read_data = '0;
                    endcase
                end
                KIND_WRITE:
                begin
                    prev = odr;
                    case (off)
                        OFS_MODE:    mode_r  = data;
                        OFS_TYPE:    type_r  = data;
                        OFS_SPEED:   speed_r = data;
                        OFS_PULL:    pull_r  = data;
                        OFS_ODR:     odr     = data[15:0];
                        OFS_BSRR:    odr     = (odr | data[15:0]) & ~data[31:16];
                        OFS_LOCK:    lock_r  = data;
                        OFS_AF_LOW:  af_lo   = data;
                        OFS_AF_HIGH: af_hi   = data;
                        default: ;
                    endcase
                    changed = prev ^ odr;
                    total = 0;
                    for (int i = 0; i < PIN_COUNT_DEFAULT; i++)
                        if (changed[i])
                            total++;
                    if (notify && total != 0)
                    begin
                        n = 0;
                        for (int i = 0; i < PIN_COUNT_DEFAULT; i++)
                        begin
                            if (changed[i])
                            begin
                                n++;
                                r.output_pins = odr;
                                r.has_event   = 1'b1;
                                r.event_pin   = i[3:0];
                                r.event_level = odr[i];
                                r.last        = (n == total);
                                pending_results.push_back(r);
                            end
                        end
                        return;
                    end
                end
                KIND_SET_PIN:
                begin
                    if (pin < PIN_COUNT_DEFAULT)
                        idr[pin] = lvl;
                end
                default:
                    soft_reset();
            endcase
            r.output_pins = odr;
            pending_results.push_back(r);
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] tdata, logic tuser, logic tlast);
            gpio_result_t got;
            gpio_result_t want;
            got.read_data   = tdata[31:0];
            got.output_pins = tdata[47:32];
            got.event_pin   = tdata[51:48];
            got.event_level = tdata[52];
            got.has_event   = tuser;
            got.last        = tlast;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: rd=%h pins=%h ev=%b pin=%0d lvl=%b last=%b",
                             got.read_data, got.output_pins, got.has_event, got.event_pin,
                             got.event_level, got.last);
                return;
            end
            want = pending_results.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"result mismatch: exp rd=%h pins=%h ev=%b pin=%0d lvl=%b last=%b",
                              " / got rd=%h pins=%h ev=%b pin=%0d lvl=%b last=%b"},
                             want.read_data, want.output_pins, want.has_event, want.event_pin,
                             want.event_level, want.last,
                             got.read_data, got.output_pins, got.has_event, got.event_pin,
                             got.event_level, got.last);
            end
        endfunction
    endclass

    localparam int CYCLE_LIMIT = 200000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [1:0]            cfg_index = '0;
    logic [31:0]           cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [1:0]            s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;

    gpio_port_shadow       book;
    int unsigned           cycle_count = 0;
    bit                    hold_request = 1'b0;
    bit                    hold_taken = 1'b0;

    logic [9:0] known_ofs [10] = '{OFS_MODE, OFS_TYPE, OFS_SPEED, OFS_PULL, OFS_IDR,
                                   OFS_ODR, OFS_BSRR, OFS_LOCK, OFS_AF_LOW, OFS_AF_HIGH};

    gpio_port_register_block_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL gpio_port_register_block_unit");
            $finish;
        end
    end

    // beat monitor: inputs noted before results are checked
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                book.note_item(item_kind_t'(s_axis_tuser), s_axis_tdata[9:0],
                               s_axis_tdata[41:10], s_axis_tdata[45:42], s_axis_tdata[46]);
            if (m_axis_tvalid && m_axis_tready)
                book.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end
    end

    // result side backpressure
    initial
    begin : result_side
        int style;
        style = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request && !hold_taken)
            begin
                hold_taken = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (300) @(posedge clk);
            end
            if ($urandom_range(0, 47) == 0)
                style = $urandom_range(0, 3);
            case (style)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= 1'($urandom_range(0, 1));
                2:       m_axis_tready <= (cycle_count % 4 != 0);
                default: m_axis_tready <= ($urandom_range(0, 5) != 0);
            endcase
        end
    end

    task automatic send_item(item_kind_t kind, logic [9:0] off, logic [31:0] data,
                             logic [3:0] pin, logic lvl);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {1'b0, lvl, pin, data, off};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic pause(int n);
        s_axis_tvalid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic write_config(logic [31:0] mode_v, logic [31:0] speed_v,
                                logic [31:0] pull_v, logic notify_v);
        logic [31:0] vals [4];
        vals = '{mode_v, speed_v, pull_v, {31'h0, notify_v}};
        cfg_we <= 1'b1;
        for (int i = 0; i < 4; i++)
        begin
            cfg_index <= i[1:0];
            cfg_wdata <= vals[i];
            @(posedge clk);
            book.set_config(i[1:0], vals[i]);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (book.pending_results.size() != 0);
        repeat (6) @(posedge clk);
    endtask

    task automatic run_directed();
        send_item(KIND_READ,  OFS_MODE,   32'h0,         4'd0,  1'b0);
        send_item(KIND_READ,  OFS_IDR,    32'hFFFF_FFFF, 4'd15, 1'b1);
        send_item(KIND_READ,  OFS_BSRR,   32'h0,         4'd0,  1'b0);
        send_item(KIND_READ,  10'h3FC,    32'h0,         4'd0,  1'b0);
        send_item(KIND_READ,  10'h002,    32'h0,         4'd0,  1'b0);
        send_item(KIND_WRITE, OFS_ODR,    32'hFFFF_FFFF, 4'd0,  1'b0);
        send_item(KIND_WRITE, OFS_BSRR,   32'hFFFF_0000, 4'd0,  1'b0);
        send_item(KIND_WRITE, OFS_BSRR,   32'h0001_0001, 4'd0,  1'b0);
        send_item(KIND_WRITE, OFS_BSRR,   32'h0000_8001, 4'd0,  1'b0);
        send_item(KIND_WRITE, OFS_ODR,    32'h1234_8001, 4'd0,  1'b0);
        send_item(KIND_READ,  OFS_ODR,    32'h0,         4'd0,  1'b0);
        send_item(KIND_WRITE, OFS_MODE,   32'hFFFF_FFFF, 4'd0,  1'b0);
        send_item(KIND_WRITE, OFS_LOCK,   32'h0001_00FF, 4'd0,  1'b0);
        send_item(KIND_WRITE, OFS_AF_HIGH, 32'hA5A5_5A5A, 4'd0, 1'b0);
        send_item(KIND_WRITE, 10'h3FC,    32'hFFFF_FFFF, 4'd0,  1'b0);
        send_item(KIND_WRITE, OFS_IDR,    32'h0,         4'd0,  1'b0);
        send_item(KIND_SET_PIN, 10'h0,    32'h0,         4'd15, 1'b0);
        send_item(KIND_SET_PIN, 10'h0,    32'h0,         4'd0,  1'b0);
        send_item(KIND_READ,  OFS_IDR,    32'h0,         4'd0,  1'b0);
        send_item(KIND_SOFT_RESET, 10'h0, 32'h0,         4'd0,  1'b0);
        send_item(KIND_READ,  OFS_MODE,   32'h0,         4'd0,  1'b0);
        send_item(KIND_READ,  OFS_IDR,    32'h0,         4'd0,  1'b0);
    endtask

    task automatic run_random(int count);
        int          burst;
        int          pick;
        item_kind_t  kind;
        logic [9:0]  off;
        logic [31:0] data;
        burst = 0;
        for (int i = 0; i < count; i++)
        begin
            if (burst == 0)
            begin
                burst = $urandom_range(1, 12);
                if ($urandom_range(0, 2) != 0)
                    pause($urandom_range(1, 6));
            end
            burst--;
            off  = 10'($urandom_range(0, 1023));
            data = $urandom();
            pick = $urandom_range(0, 99);
            if (pick < 30)
            begin
                kind = KIND_READ;
                if ($urandom_range(0, 6) != 0)
                    off = known_ofs[$urandom_range(0, 9)];
            end
            else if (pick < 68)
            begin
                kind = KIND_WRITE;
                if ($urandom_range(0, 1) == 0)
                    off = ($urandom_range(0, 1) == 0) ? OFS_ODR : OFS_BSRR;
                else if ($urandom_range(0, 5) != 0)
                    off = known_ofs[$urandom_range(0, 9)];
            end
            else if (pick < 95)
                kind = KIND_SET_PIN;
            else
                kind = KIND_SOFT_RESET;
            send_item(kind, off, data, 4'($urandom_range(0, 15)),
                      1'($urandom_range(0, 1)));
        end
    endtask

    initial
    begin : stimulus
        logic [31:0] mode_v;
        logic [31:0] speed_v;
        logic [31:0] pull_v;
        logic        notify_v;
        book = new();
        book.hard_reset();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int ph = 0; ph < 6; ph++)
        begin
            mode_v   = $urandom();
            speed_v  = $urandom();
            pull_v   = $urandom();
            notify_v = 1'b1;
            case (ph)
                0:
                begin
                    mode_v  = '0;
                    speed_v = '0;
                    pull_v  = '0;
                end
                1:
                begin
                    mode_v   = '1;
                    speed_v  = '1;
                    pull_v   = '1;
                    notify_v = 1'b0;
                end
                4:
                begin
                    mode_v  = '1;
                    speed_v = '0;
                end
                5: notify_v = 1'b0;
                default: ;
            endcase
            write_config(mode_v, speed_v, pull_v, notify_v);
            if (ph == 0)
                run_directed();
            if (ph == 3)
                hold_request = 1'b1;
            run_random(42);
            drain();
        end
        if (book.mismatches == 0 && book.pending_results.size() == 0)
            $display("PASS gpio_port_register_block_unit");
        else
            $display("FAIL gpio_port_register_block_unit");
        $finish;
    end

endmodule

// File: filelist.f
design/gpioprb_pkg.sv
design/gpio_port_register_block_unit.sv
design/gpioprb_checker.sv
tb/gpio_port_register_block_unit_tb.sv
